@@ design/value_noise_2d_assert.svh @@
// Assertion macros for the value noise block.
`ifndef VALUE_NOISE_2D_ASSERT_SVH
`define VALUE_NOISE_2D_ASSERT_SVH

`ifndef SYNTHESIS
`define VN2D_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VN2D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VN2D_ASSERT_IMP(lbl, ante, cons, msg)
`define VN2D_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/vn2d_pkg.sv @@
// Package with constants, types and arithmetic helpers of the value noise block.
package vn2d_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int OUT_FRAC_BITS = 24;
    localparam int CORNER_FRAC   = 24;

    localparam int COORD_W  = 32;
    localparam int CORNER_W = CORNER_FRAC + 1;
    localparam int DIFF_W   = CORNER_W + 1;
    localparam int FADE_W   = FRAC_BITS + 6;
    localparam int FADE_PW  = FRAC_BITS + 1 + FADE_W;
    localparam int WGT_W    = FRAC_BITS + 2;
    localparam int LERP_PW  = DIFF_W + WGT_W;
    localparam int NSTG     = 9;

    localparam logic [31:0] MIX_K1  = 32'h7feb352d;
    localparam logic [31:0] MIX_K2  = 32'h846ca68b;
    localparam logic [31:0] SEED_K  = 32'h9e3779b1;
    localparam logic [31:0] XCELL_K = 32'h85ebca6b;
    localparam logic [31:0] ZCELL_K = 32'hc2b2ae35;

    localparam logic [0:0] REG_NOISE_SEED = 1'b0;

    typedef logic [FRAC_BITS-1:0]       frac_t;
    typedef logic signed [FADE_W-1:0]   fade_t;
    typedef logic signed [WGT_W-1:0]    wgt_t;
    typedef logic signed [CORNER_W-1:0] corner_t;

    localparam fade_t FADE_C15 = FADE_W'(15 << FRAC_BITS);
    localparam fade_t FADE_C10 = FADE_W'(10 << FRAC_BITS);

    function automatic logic [31:0] xsh(input logic [31:0] h, input int s);
        return h ^ (h >> s);
    endfunction

    function automatic fade_t fade_first(input frac_t f);
        fade_t f4;
        fade_t f2;
        f4 = signed'(FADE_W'({f, 2'b00}));
        f2 = signed'(FADE_W'({f, 1'b0}));
        return f4 + f2 - FADE_C15;
    endfunction

    function automatic fade_t fade_mul(input frac_t f, input fade_t p);
        logic signed [FRAC_BITS:0] fs;
        logic signed [FADE_PW-1:0] prod;
        fs = signed'({1'b0, f});
        prod = fs * p;
        return FADE_W'(prod >>> FRAC_BITS);
    endfunction

    function automatic corner_t corner_of(input logic [31:0] h);
        logic [31:0] g;
        g = xsh(h, 16);
        return signed'({~g[31], g[30:8], 1'b0});
    endfunction

    function automatic corner_t lerp(input corner_t a, input corner_t b, input wgt_t w);
        logic signed [DIFF_W-1:0]  d;
        logic signed [LERP_PW-1:0] prod;
        d = DIFF_W'(b) - DIFF_W'(a);
        prod = d * w;
        return a + CORNER_W'(prod >>> FRAC_BITS);
    endfunction

endpackage

@@ design/value_noise_2d.sv @@
// Seeded 2D value noise with quintic fade, nine-stage pipeline.
//
// Input channel: x_pos, z_pos (signed Q16.16) with in_valid / in_ready.
// Output channel: noise_value (signed Q1.24) with out_valid / out_ready.
// Configuration: APB-style port, one register noise_seed at byte addresses 0-3;
// writes at 4 to 7 are ignored and read back as zero. pready is always high.
// Write the seed only while no beat is in flight.
//
// Throughput: one point per cycle while out_ready stays high. Stage 1 splits
// cell and fraction; stages 2 to 6 hold the cell constant and avalanche
// multiplies beside the four fade multiplies; stage 7 recenters the corners;
// stages 8 and 9 interpolate. Valid bits travel with the data.
//
// Reset clears all valid bits and sets the seed to zero.
// A stalled receiver holds the last stage; earlier stages keep filling until
// the pipeline is full, then in_ready drops. No beat is lost or repeated.
module value_noise_2d
    import vn2d_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [31:0]       x_pos,
    input  logic signed [31:0]       z_pos,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [24:0]       noise_value,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

`include "value_noise_2d_assert.svh"

    logic [31:0]     seed_reg;
    logic [31:0]     seed_mix_reg;
    logic            cfg_wr;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    // stage 1
    logic [31:0] x0_s1_reg, x1_s1_reg, z0_s1_reg, z1_s1_reg;
    frac_t       fx_s1_reg, fz_s1_reg;
    // stage 2
    logic [31:0] mx_s2_reg [2];
    logic [31:0] mz_s2_reg [2];
    frac_t       fx_s2_reg, fz_s2_reg;
    fade_t       pu_s2_reg, pv_s2_reg;
    // stage 3
    logic [31:0] hx_s3_reg [2];
    logic [31:0] mz_s3_reg [2];
    frac_t       fx_s3_reg, fz_s3_reg;
    fade_t       pu_s3_reg, pv_s3_reg;
    // stage 4
    logic [31:0] hx_s4_reg [2];
    logic [31:0] mz_s4_reg [2];
    frac_t       fx_s4_reg, fz_s4_reg;
    fade_t       pu_s4_reg, pv_s4_reg;
    // stage 5 to 9
    logic [31:0] h_s5_reg [4];
    logic [31:0] h_s6_reg [4];
    corner_t     c_s7_reg [4];
    wgt_t        u_s5_reg, v_s5_reg, u_s6_reg, v_s6_reg, u_s7_reg, v_s7_reg;
    corner_t     e_s8_reg [2];
    wgt_t        v_s8_reg;
    corner_t     r_s9_reg;
    corner_t     r_s9_next;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NOISE_SEED);
    assign prdata = (paddr[2] == REG_NOISE_SEED) ? seed_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg     <= '0;
            seed_mix_reg <= '0;
        end
        else if (cfg_wr)
        begin
            seed_reg     <= pwdata;
            seed_mix_reg <= pwdata * SEED_K;
        end
    end

    // stage enables: a stage loads when empty or when its beat moves on
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready    = en[0];
    assign out_valid   = vld_reg[NSTG-1];
    assign noise_value = r_s9_reg;

    // stage 1: split into cell and fraction
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_s1_reg <= 32'(x_pos >>> FRAC_BITS);
            x1_s1_reg <= 32'(x_pos >>> FRAC_BITS) + 32'd1;
            z0_s1_reg <= 32'(z_pos >>> FRAC_BITS);
            z1_s1_reg <= 32'(z_pos >>> FRAC_BITS) + 32'd1;
            fx_s1_reg <= x_pos[FRAC_BITS-1:0];
            fz_s1_reg <= z_pos[FRAC_BITS-1:0];
        end
    end

    // stage 2: cell constants, first fade step
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mx_s2_reg[0] <= x0_s1_reg * XCELL_K;
            mx_s2_reg[1] <= x1_s1_reg * XCELL_K;
            mz_s2_reg[0] <= z0_s1_reg * ZCELL_K;
            mz_s2_reg[1] <= z1_s1_reg * ZCELL_K;
            fx_s2_reg    <= fx_s1_reg;
            fz_s2_reg    <= fz_s1_reg;
            pu_s2_reg    <= fade_mul(fx_s1_reg, fade_first(fx_s1_reg)) + FADE_C10;
            pv_s2_reg    <= fade_mul(fz_s1_reg, fade_first(fz_s1_reg)) + FADE_C10;
        end
    end

    // stage 3 and 4: x-axis avalanche and fade steps
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 2; i++)
            begin
                hx_s3_reg[i] <= xsh(seed_mix_reg ^ mx_s2_reg[i], 16) * MIX_K1;
                mz_s3_reg[i] <= mz_s2_reg[i];
            end
            fx_s3_reg <= fx_s2_reg;
            fz_s3_reg <= fz_s2_reg;
            pu_s3_reg <= fade_mul(fx_s2_reg, pu_s2_reg);
            pv_s3_reg <= fade_mul(fz_s2_reg, pv_s2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 2; i++)
            begin
                hx_s4_reg[i] <= xsh(hx_s3_reg[i], 15) * MIX_K2;
                mz_s4_reg[i] <= mz_s3_reg[i];
            end
            fx_s4_reg <= fx_s3_reg;
            fz_s4_reg <= fz_s3_reg;
            pu_s4_reg <= fade_mul(fx_s3_reg, pu_s3_reg);
            pv_s4_reg <= fade_mul(fz_s3_reg, pv_s3_reg);
        end
    end

    // stage 5 to 7: per-corner avalanche; corner g has x bit g[0], z bit g[1]
    for (genvar g = 0; g < 4; g++)
    begin : g_corner
        always_ff @(posedge clk)
        begin
            if (en[4])
            begin
                h_s5_reg[g] <= xsh(xsh(hx_s4_reg[g % 2], 16) ^ mz_s4_reg[g / 2], 16) * MIX_K1;
            end
            if (en[5])
            begin
                h_s6_reg[g] <= xsh(h_s5_reg[g], 15) * MIX_K2;
            end
            if (en[6])
            begin
                c_s7_reg[g] <= corner_of(h_s6_reg[g]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            u_s5_reg <= WGT_W'(fade_mul(fx_s4_reg, pu_s4_reg));
            v_s5_reg <= WGT_W'(fade_mul(fz_s4_reg, pv_s4_reg));
        end
        if (en[5])
        begin
            u_s6_reg <= u_s5_reg;
            v_s6_reg <= v_s5_reg;
        end
        if (en[6])
        begin
            u_s7_reg <= u_s6_reg;
            v_s7_reg <= v_s6_reg;
        end
    end

    // stage 8 and 9: blend along x, then along z
    always_comb
    begin
        r_s9_next = lerp(e_s8_reg[0], e_s8_reg[1], v_s8_reg) >>> (CORNER_FRAC - OUT_FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            e_s8_reg[0] <= lerp(c_s7_reg[0], c_s7_reg[1], u_s7_reg);
            e_s8_reg[1] <= lerp(c_s7_reg[2], c_s7_reg[3], u_s7_reg);
            v_s8_reg    <= v_s7_reg;
        end
        if (en[8])
        begin
            r_s9_reg <= r_s9_next;
        end
    end

    `VN2D_ASSERT_NXT(a_in_enters, in_valid && in_ready, vld_reg[0], "accepted beat missing in stage 1")
    `VN2D_ASSERT_IMP(a_full_stall, !in_ready, (&vld_reg) && !out_ready, "input stalled with room in pipeline")
    `VN2D_ASSERT_NXT(a_cfg_ignore, psel && penable && pwrite && paddr[2], $stable(seed_reg), "write to unknown register changed seed")
    `VN2D_ASSERT_IMP(a_seed_mix, 1'b1, seed_mix_reg == seed_reg * SEED_K, "seed mix out of step with seed")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking bench for the value noise block: random and edge-case points under seed changes.
`timescale 1ns / 100ps

module testbench;
    import vn2d_pkg::*;

    localparam int          RANDOM_PER_PHASE = 300;
    localparam int          PIPE_SETTLE      = 16;
    localparam int          CYCLE_LIMIT      = 1000000;
    localparam int          PRINT_CAP        = 40;
    localparam logic [2:0]  SEED_ADDR        = {REG_NOISE_SEED, 2'b00};
    localparam logic [2:0]  SPARE_ADDR       = 3'd4;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] z;
    } point_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] x_pos = '0;
    logic signed [31:0] z_pos = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [24:0] noise_value;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    point_t             point_queue[$];
    logic signed [24:0] noise_expected[$];
    logic [31:0]        seed_mirror = '0;
    logic               steady = 1'b0;
    int                 mismatch_count = 0;
    int                 send_gap = 0;
    int                 recv_stall = 0;
    int                 cycle_count = 0;
    logic [15:0]        edge_fracs[4] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000};

    value_noise_2d u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_pos       (x_pos),
        .z_pos       (z_pos),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .noise_value (noise_value),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] scramble(input logic [31:0] h);
        h = h ^ (h >> 16);
        h = h * MIX_K1;
        h = h ^ (h >> 15);
        h = h * MIX_K2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic longint corner_level(input logic [31:0] seed, input logic [31:0] cx,
                                            input logic [31:0] cz);
        logic [31:0] h;
        longint      top;
        h = seed * SEED_K;
        h = h ^ (cx * XCELL_K);
        h = scramble(h);
        h = h ^ (cz * ZCELL_K);
        h = scramble(h);
        top = longint'(h >> 8);
        return 2 * top - (longint'(1) << CORNER_FRAC);
    endfunction

    function automatic longint fade_curve(input longint f);
        longint one;
        longint p;
        one = longint'(1) << FRAC_BITS;
        p = 6 * f - 15 * one;
        p = ((f * p) >>> FRAC_BITS) + 10 * one;
        repeat (3) p = (f * p) >>> FRAC_BITS;
        return p;
    endfunction

    function automatic longint mix_between(input longint a, input longint b, input longint w);
        return a + (((b - a) * w) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [24:0] predict_noise(input logic signed [31:0] x,
                                                         input logic signed [31:0] z,
                                                         input logic [31:0] seed);
        logic [31:0] x0;
        logic [31:0] z0;
        logic [31:0] x1;
        logic [31:0] z1;
        longint      fx;
        longint      fz;
        longint      u;
        longint      v;
        longint      r;
        x0 = x >>> FRAC_BITS;
        z0 = z >>> FRAC_BITS;
        x1 = x0 + 32'd1;
        z1 = z0 + 32'd1;
        fx = longint'(x[FRAC_BITS-1:0]);
        fz = longint'(z[FRAC_BITS-1:0]);
        u = fade_curve(fx);
        v = fade_curve(fz);
        r = mix_between(mix_between(corner_level(seed, x0, z0), corner_level(seed, x1, z0), u),
                        mix_between(corner_level(seed, x0, z1), corner_level(seed, x1, z1), u),
                        v);
        r = r >>> (CORNER_FRAC - OUT_FRAC_BITS);
        return r[24:0];
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] random_coord();
        logic [31:0] c;
        c = $urandom;
        case ($urandom_range(0, 3))
            2: c = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            3: c[15:0] = edge_fracs[2'($urandom_range(0, 3))];
            default: ;
        endcase
        return signed'(c);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH @%0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic add_point(input logic [31:0] x, input logic [31:0] z);
        point_queue.push_back('{x: signed'(x), z: signed'(z)});
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (wr && addr == SEED_ADDR)
            seed_mirror = data;
        if (!wr && prdata !== seed_mirror)
            report_mismatch($sformatf("seed readback %h, want %h", prdata, seed_mirror));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (point_queue.size() != 0 || in_valid || noise_expected.size() != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                noise_expected.push_back(predict_noise(x_pos, z_pos, seed_mirror));
            if (!(in_valid && !in_ready))
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (point_queue.size() != 0)
                begin
                    point_t p;
                    p = point_queue.pop_front();
                    x_pos <= p.x;
                    z_pos <= p.z;
                    in_valid <= 1'b1;
                    send_gap <= steady ? 0 : idle_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (noise_expected.size() == 0)
                    report_mismatch($sformatf("unexpected beat %h", noise_value));
                else
                begin
                    logic signed [24:0] want;
                    want = noise_expected.pop_front();
                    if (noise_value !== want)
                        report_mismatch($sformatf("noise_value %h, want %h", noise_value, want));
                end
            end
            if (recv_stall > 0)
            begin
                out_ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_stall <= steady ? 0 : idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] seeds[5];
        seeds = '{32'hFFFF_FFFF, 32'h0000_0001, $urandom, 32'h8000_0000, $urandom};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        apb_access(1'b0, SEED_ADDR, '0);

        add_point(32'h0000_0000, 32'h0000_0000);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000);
        add_point(32'h7FFF_FFFF, 32'h8000_0000);
        add_point(32'h8000_0000, 32'h7FFF_FFFF);
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_point(32'hFFFF_0000, 32'h0000_0000);
        add_point(32'h0000_0000, 32'hFFFF_0000);
        add_point(32'hFFFF_8000, 32'hFFFF_0001);
        add_point(32'h0001_0000, 32'h0001_0000);
        add_point(32'h0000_FFFF, 32'h0000_FFFF);
        add_point(32'h0000_0001, 32'h0000_8000);
        add_point(32'h0000_8000, 32'h0000_0001);
        add_point(32'h7FFF_0000, 32'h7FFF_FFFF);
        add_point(32'h8000_FFFF, 32'h8000_0001);
        add_point(32'h5555_5555, 32'hAAAA_AAAA);
        add_point(32'hAAAA_AAAA, 32'h5555_5555);
        add_point(32'hFFFE_FFFF, 32'h0001_FFFF);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            apb_access(1'b1, SEED_ADDR, seeds[ph]);
            apb_access(1'b0, SEED_ADDR, '0);
            if (ph == 3)
            begin
                apb_access(1'b1, SPARE_ADDR, $urandom);
                apb_access(1'b0, SEED_ADDR, '0);
            end
            steady = (ph == 2);
            if (ph == 0)
            begin
                add_point(32'h0000_0000, 32'hFFFF_FFFF);
                add_point(32'h7FFF_FFFF, 32'h0000_FFFF);
                add_point(32'h8000_0000, 32'hFFFF_0000);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                add_point(random_coord(), random_coord());
            drain();
            steady = 1'b0;
        end

        repeat (PIPE_SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/vn2d_pkg.sv
design/value_noise_2d.sv
tb/sv/testbench.sv
